// ----- rtl/wsdf_pkg.sv -----
// Types and constants shared by the websocket frame deframer.
package wsdf_pkg;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT16,
    PH_EXT64,
    PH_KEY,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    K_DATA      = 2'd0,
    K_EMPTY_END = 2'd1,
    K_REPLY     = 2'd2,
    K_CLOSED    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       message_end;
    logic       close_reason;
  } result_t;

  localparam int unsigned MaxResults = 3;

  localparam logic [7:0] FinMask    = 8'h80;
  localparam logic [7:0] RsvMask    = 8'h70;
  localparam logic [7:0] OpcodeMask = 8'h0f;
  localparam logic [7:0] LenMask    = 8'h7f;
  localparam logic [6:0] Len16Code  = 7'd126;
  localparam logic [6:0] Len64Code  = 7'd127;

  localparam logic [3:0] OpLastData = 4'h2;
  localparam logic [3:0] OpClose    = 4'h8;
  localparam logic [3:0] OpPing     = 4'h9;

  localparam logic [7:0] ReplyClose = 8'h88;
  localparam logic [7:0] ReplyPong  = 8'h8a;
  localparam logic [7:0] ReplyLen0  = 8'h00;

  localparam logic [2:0] Ext16LastIdx = 3'd1;
  localparam logic [2:0] Ext64LastIdx = 3'd7;
  localparam logic [2:0] KeyLastIdx   = 3'd3;

endpackage

// ----- rtl/wsdf_if.sv -----
// Valid/ready channel interfaces for received bytes and parsed results.
interface wsdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsdf_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic       message_end;
  logic       close_reason;
  logic       last;

  modport source (output valid, output kind, output value, output message_end,
                  output close_reason, output last, input ready);
  modport sink (input valid, input kind, input value, input message_end,
                input close_reason, input last, output ready);
endinterface

// ----- rtl/websocket_frame_deframer.sv -----
// Websocket frame deframer: parses a received frame byte stream into results.
//
// Channel rx carries one received byte per item; channel res carries the
// results, each with kind, value, message_end, close_reason and last.
// Each accepted byte is parsed in the cycle it is taken and its results
// (zero to three) are loaded into a result buffer; the first appears on res
// in the cycle after the byte is accepted. While res is ready, a byte that
// gives at most one result is followed by the next byte in the next cycle,
// so payload streams at one byte per cycle. A close or ping frame end gives
// two or three results and holds rx until the last is taken, as the buffer
// drains one result per cycle while res is ready, on its single output port.
// When res stalls, the buffer holds its results and rx is held off while
// any result waits in the buffer. Bytes after the link closes are taken
// and dropped until reset. Reset (rst, synchronous) returns the parser to
// the first header byte, opens the link and empties the buffer; no clearing
// pass is needed.
module websocket_frame_deframer
  import wsdf_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  wsdf_byte_if.sink            rx,
  wsdf_result_if.source        res
);

  phase_t                 parse_phase, parse_phase_next;
  logic [2:0]             phase_byte_count, phase_byte_count_next;
  logic                   frame_fin, frame_fin_next;
  logic [3:0]             frame_opcode, frame_opcode_next;
  logic                   frame_masked, frame_masked_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [LENGTH_BITS-1:0] remaining_length, remaining_length_next;
  logic [1:0]             payload_position, payload_position_next;
  logic                   link_closed, link_closed_next;

  result_t                res_buf [MaxResults];
  logic [1:0]             buf_count;
  logic [1:0]             buf_idx;
  logic                   buf_valid;

  logic                   in_fire, out_fire, buf_last;
  logic [6:0]             len7;
  logic                   rsv_set, is_data;
  logic [LENGTH_BITS-1:0] len_dec, ext_len;
  logic                   pay_done, ext_last, frame_end, had_payload;
  logic [7:0]             key_byte;
  result_t                new_res [MaxResults];
  logic [1:0]             new_count;

  assign buf_last = (buf_idx == buf_count - 2'd1);
  assign out_fire = res.valid && res.ready;
  assign rx.ready = !buf_valid || (res.ready && buf_last);
  assign in_fire  = rx.valid && rx.ready;

  assign res.valid        = buf_valid;
  assign res.kind         = res_buf[buf_idx].kind;
  assign res.value        = res_buf[buf_idx].value;
  assign res.message_end  = res_buf[buf_idx].message_end;
  assign res.close_reason = res_buf[buf_idx].close_reason;
  assign res.last         = buf_last;

  always_comb begin
    len7     = rx.rx_byte[6:0] & LenMask[6:0];
    rsv_set  = (rx.rx_byte & RsvMask) != 8'h00;
    is_data  = frame_opcode <= OpLastData;
    len_dec  = remaining_length - LENGTH_BITS'(1);
    pay_done = (len_dec == '0);
    ext_len  = {remaining_length[LENGTH_BITS-9:0], rx.rx_byte};
    ext_last = (parse_phase == PH_EXT16) ? (phase_byte_count >= Ext16LastIdx)
                                         : (phase_byte_count >= Ext64LastIdx);
    case (payload_position)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
    if (!frame_masked) begin
      key_byte = 8'h00;
    end
    had_payload = 1'b0;
    frame_end   = 1'b0;
    case (parse_phase)
      PH_HDR1: begin
        frame_end = (len7 != Len16Code) && (len7 != Len64Code) &&
                    !rx.rx_byte[7] && (len7 == 7'd0);
      end
      PH_EXT16, PH_EXT64: begin
        frame_end = ext_last && !frame_masked && (ext_len == '0);
      end
      PH_KEY: begin
        frame_end = (phase_byte_count >= KeyLastIdx) && (remaining_length == '0);
      end
      PH_PAYLOAD: begin
        frame_end   = pay_done;
        had_payload = 1'b1;
      end
      default: begin
        frame_end = 1'b0;
      end
    endcase
  end

  always_comb begin
    parse_phase_next      = parse_phase;
    phase_byte_count_next = phase_byte_count;
    frame_fin_next        = frame_fin;
    frame_opcode_next     = frame_opcode;
    frame_masked_next     = frame_masked;
    mask_key_next         = mask_key;
    remaining_length_next = remaining_length;
    payload_position_next = payload_position;
    link_closed_next      = link_closed;
    if (in_fire && !link_closed) begin
      case (parse_phase)
        PH_HDR0: begin
          if (rsv_set) begin
            link_closed_next = 1'b1;
          end else begin
            frame_fin_next    = (rx.rx_byte & FinMask) != 8'h00;
            frame_opcode_next = rx.rx_byte[3:0] & OpcodeMask[3:0];
            parse_phase_next  = PH_HDR1;
          end
        end
        PH_HDR1: begin
          frame_masked_next     = rx.rx_byte[7];
          mask_key_next         = '0;
          remaining_length_next = '0;
          phase_byte_count_next = '0;
          if (len7 == Len16Code) begin
            parse_phase_next = PH_EXT16;
          end else if (len7 == Len64Code) begin
            parse_phase_next = PH_EXT64;
          end else begin
            remaining_length_next = LENGTH_BITS'(len7);
            payload_position_next = '0;
            if (rx.rx_byte[7]) begin
              parse_phase_next = PH_KEY;
            end else if (len7 == 7'd0) begin
              parse_phase_next = PH_HDR0;
            end else begin
              parse_phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_EXT16, PH_EXT64: begin
          remaining_length_next = ext_len;
          if (ext_last) begin
            payload_position_next = '0;
            phase_byte_count_next = '0;
            if (frame_masked) begin
              mask_key_next    = '0;
              parse_phase_next = PH_KEY;
            end else if (ext_len == '0) begin
              parse_phase_next = PH_HDR0;
            end else begin
              parse_phase_next = PH_PAYLOAD;
            end
          end else begin
            phase_byte_count_next = phase_byte_count + 3'd1;
          end
        end
        PH_KEY: begin
          mask_key_next = {mask_key[23:0], rx.rx_byte};
          if (phase_byte_count >= KeyLastIdx) begin
            phase_byte_count_next = '0;
            parse_phase_next = (remaining_length == '0) ? PH_HDR0 : PH_PAYLOAD;
          end else begin
            phase_byte_count_next = phase_byte_count + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          remaining_length_next = len_dec;
          payload_position_next = payload_position + 2'd1;
          if (pay_done) begin
            parse_phase_next      = PH_HDR0;
            phase_byte_count_next = '0;
          end
        end
        default: begin
          parse_phase_next      = PH_HDR0;
          phase_byte_count_next = '0;
        end
      endcase
      if (frame_end && (frame_opcode == OpClose)) begin
        link_closed_next = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MaxResults; i++) begin
      new_res[i] = '{kind: K_DATA, value: 8'h00, message_end: 1'b0,
                     close_reason: 1'b0};
    end
    new_count = 2'd0;
    if (!link_closed) begin
      if (parse_phase == PH_HDR0 && rsv_set) begin
        new_res[0].kind         = K_CLOSED;
        new_res[0].close_reason = 1'b1;
        new_count               = 2'd1;
      end else if (parse_phase == PH_PAYLOAD && is_data) begin
        new_res[0].value       = rx.rx_byte ^ key_byte;
        new_res[0].message_end = pay_done && frame_fin;
        new_count              = 2'd1;
      end else if (frame_end) begin
        if (is_data) begin
          if (!had_payload && frame_fin) begin
            new_res[0].kind        = K_EMPTY_END;
            new_res[0].message_end = 1'b1;
            new_count              = 2'd1;
          end
        end else if (frame_opcode == OpClose) begin
          new_res[0].kind  = K_REPLY;
          new_res[0].value = ReplyClose;
          new_res[1].kind  = K_REPLY;
          new_res[1].value = ReplyLen0;
          new_res[2].kind  = K_CLOSED;
          new_count        = 2'd3;
        end else if (frame_opcode == OpPing) begin
          new_res[0].kind  = K_REPLY;
          new_res[0].value = ReplyPong;
          new_res[1].kind  = K_REPLY;
          new_res[1].value = ReplyLen0;
          new_count        = 2'd2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= PH_HDR0;
      phase_byte_count <= '0;
      frame_fin        <= 1'b0;
      frame_opcode     <= '0;
      frame_masked     <= 1'b0;
      mask_key         <= '0;
      remaining_length <= '0;
      payload_position <= '0;
      link_closed      <= 1'b0;
    end else begin
      parse_phase      <= parse_phase_next;
      phase_byte_count <= phase_byte_count_next;
      frame_fin        <= frame_fin_next;
      frame_opcode     <= frame_opcode_next;
      frame_masked     <= frame_masked_next;
      mask_key         <= mask_key_next;
      remaining_length <= remaining_length_next;
      payload_position <= payload_position_next;
      link_closed      <= link_closed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      buf_idx   <= '0;
      buf_count <= '0;
    end else begin
      if (in_fire && new_count != 2'd0) begin
        buf_valid <= 1'b1;
        buf_idx   <= '0;
        buf_count <= new_count;
      end else if (out_fire) begin
        if (buf_last) begin
          buf_valid <= 1'b0;
        end else begin
          buf_idx <= buf_idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && new_count != 2'd0) begin
      for (int i = 0; i < MaxResults; i++) begin
        res_buf[i] <= new_res[i];
      end
    end
  end

endmodule
